// ----- hw/rtl/cfdl_pkg.sv -----
package cfdl_pkg;

   // sample store geometry
   localparam int STORE_AW    = 12;
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int OCC_W       = STORE_AW + 1;

   // field widths
   localparam int DELAY_W = 16;
   localparam int FRAC_W  = 8;
   localparam int FADE_W  = 17;
   localparam int REQ_W   = 24;
   localparam int SCALE_W = 16;
   localparam int COEF_W  = 17;
   localparam int PHASE_W = 3;

   // time_scale is Q4.12
   localparam int SCALE_SHIFT = 12;

   localparam int DEF_MAX_DELAY    = 4094;
   localparam int DEF_SAMPLE_WIDTH = 24;

   // configuration port
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 16;
   typedef logic [CSR_IW-1:0] csr_idx_type;
   localparam csr_idx_type REG_TIME_SCALE  = 2'd0;
   localparam csr_idx_type REG_INTERP_MODE = 2'd1;
   localparam csr_idx_type REG_XFADE_STEP  = 2'd2;

   localparam logic [SCALE_W-1:0] RST_TIME_SCALE  = 16'd4096;
   localparam logic               RST_INTERP_MODE = 1'b1;
   localparam logic [SCALE_W-1:0] RST_XFADE_STEP  = 16'd3277;

   typedef logic [PHASE_W-1:0] phase_type;
   localparam phase_type PH_NORMAL    = 3'd0;
   localparam phase_type PH_FILLING   = 3'd1;
   localparam phase_type PH_SHRINK    = 3'd2;
   localparam phase_type PH_GROWING   = 3'd3;
   localparam phase_type PH_GROW_FADE = 3'd4;

   localparam logic [COEF_W-1:0] FADE_UNITY = 17'h10000;
   localparam logic [FADE_W-1:0] FADE_SAT   = 17'h1FFFF;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic en;
      logic clear;
   } mac_ctl_type;

endpackage

// ----- hw/rtl/cfdl_if.sv -----
interface cfdl_req_if #(parameter int SW = cfdl_pkg::DEF_SAMPLE_WIDTH);
   logic                          valid;
   logic                          ready;
   logic [SW-1:0]                 audio_in;
   logic [cfdl_pkg::REQ_W-1:0]    delay_time;
   modport source (output valid, audio_in, delay_time, input ready);
   modport sink   (input valid, audio_in, delay_time, output ready);
endinterface

interface cfdl_rsp_if #(parameter int SW = cfdl_pkg::DEF_SAMPLE_WIDTH);
   logic                          valid;
   logic                          ready;
   logic [SW-1:0]                 audio_out;
   logic [cfdl_pkg::PHASE_W-1:0]  phase_code;
   logic                          delay_clamped;
   modport source (output valid, audio_out, phase_code, delay_clamped, input ready);
   modport sink   (input valid, audio_out, phase_code, delay_clamped, output ready);
endinterface

interface cfdl_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cfdl_pkg::CSR_IW-1:0]   index;
   logic [cfdl_pkg::CSR_DW-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/cfdl_store.sv -----
module cfdl_store #(
   parameter int SW = cfdl_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [cfdl_pkg::STORE_AW-1:0] wr_addr,
   input  logic [SW-1:0]                 wr_data,
   input  logic [cfdl_pkg::STORE_AW-1:0] rd_addr,
   output logic [SW-1:0]                 rd_data
);

   logic [SW-1:0] mem_ff [cfdl_pkg::STORE_DEPTH];
   logic [SW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/cfdl_mac.sv -----
module cfdl_mac #(
   parameter int AW    = 33,
   parameter int ACC_W = AW + cfdl_pkg::COEF_W + 1
) (
   input  logic                        clock,
   input  cfdl_pkg::mac_ctl_type       ctl,
   input  logic signed [AW-1:0]        a,
   input  logic [cfdl_pkg::COEF_W-1:0] b,
   output logic signed [ACC_W-1:0]     acc
);

   logic signed [ACC_W-1:0]                 acc_ff;
   logic signed [ACC_W-1:0]                 acc_in;
   logic signed [ACC_W-1:0]                 prod;
   logic signed [AW+cfdl_pkg::COEF_W:0]     mul;

   always_comb begin
      // full-width product before any resizing
      mul    = a * $signed({1'b0, b});
      prod   = ACC_W'(mul);
      acc_in = (ctl.clear ? '0 : acc_ff) + prod;
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- hw/rtl/crossfading_fractional_delay_line.sv -----
// channel  dir  handshake       word
// req_ch   in   valid / ready   audio_in, delay_time
// rsp_ch   out  valid / ready   audio_out, phase_code, delay_clamped
// csr_ch   in   valid / ready   index, data (ready always high)
// an item runs scale, decide, tap reads and accumulates, round; filling skips the
// taps, a crossfade adds a tap and a mix, on one shared mac and one store read port
// synchronous active-high reset clears control state; the store is not cleared
// a result waits in the output register while the next word is taken in
module crossfading_fractional_delay_line #(
   parameter int MAX_DELAY    = cfdl_pkg::DEF_MAX_DELAY,
   parameter int SAMPLE_WIDTH = cfdl_pkg::DEF_SAMPLE_WIDTH
) (
   input logic        clock,
   input logic        reset,
   cfdl_req_if.sink   req_ch,
   cfdl_rsp_if.source rsp_ch,
   cfdl_csr_if.sink   csr_ch
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int TAP_W  = SW + 9;
   localparam int MA_W   = (TAP_W > cfdl_pkg::REQ_W + 1) ? TAP_W : cfdl_pkg::REQ_W + 1;
   localparam int ACC_W  = MA_W + cfdl_pkg::COEF_W + 1;
   localparam int AW     = cfdl_pkg::STORE_AW;
   localparam int DW     = cfdl_pkg::DELAY_W;
   localparam int FW     = cfdl_pkg::FRAC_W;
   localparam int OW     = cfdl_pkg::OCC_W;
   localparam int CW     = cfdl_pkg::COEF_W;
   localparam int FRAC_LO = cfdl_pkg::SCALE_SHIFT;
   localparam int INT_LO  = FRAC_LO + FW;
   localparam int INT_HI  = cfdl_pkg::REQ_W + cfdl_pkg::SCALE_W - 1;
   localparam int WANT_W  = INT_HI - INT_LO + 1;
   localparam logic [DW-1:0] MAXD = DW'(MAX_DELAY);

   typedef enum logic [3:0] {
      S_IDLE, S_SCALE, S_DECIDE, S_RDA1, S_RDA0, S_MA0,
      S_RDB1, S_RDB0, S_MB0, S_MIX1, S_MIX2, S_ROUND
   } state_type;

   typedef enum logic [1:0] {FS_NONE, FS_SHRINK, FS_BACK, FS_GROW} fade_state_type;

   state_type      state_ff;
   fade_state_type fs_ff, fs_in;

   // configuration
   logic [cfdl_pkg::SCALE_W-1:0] ts_ff, step_ff;
   logic                         im_ff;

   // delay line state
   logic [AW-1:0]                wp_ff, wp_in;
   logic [OW-1:0]                occ_ff, occ_in;
   logic [DW-1:0]                cur_ff, cur_in, tgt_ff, tgt_in, off_ff, off_in;
   logic [FW-1:0]                cfr_ff, cfr_in, tfr_ff, tfr_in;
   logic [cfdl_pkg::FADE_W-1:0]  fp_ff, fp_in;
   logic                         started_ff;

   // per-word work registers
   logic [SW-1:0]                smp_ff;
   logic [cfdl_pkg::REQ_W-1:0]   mag_ff;
   logic [AW-1:0]                base_ff, base_in, offa_ff, offa_in, offb_ff, offb_in;
   logic [FW-1:0]                fa_ff, fa_in, fb_ff, fb_in;
   logic [CW-1:0]                c_ff, c_in;
   logic                         fade_ff, fade_in, fill_ff, fill_in, clamp_ff, clamp_in;
   cfdl_pkg::phase_type          phase_ff, phase_in;
   logic [TAP_W-1:0]             tapa_ff, tapb_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [SW-1:0]                rsp_audio_ff;
   cfdl_pkg::phase_type          rsp_phase_ff;
   logic                         rsp_clamp_ff;

   // shared unit and store
   cfdl_pkg::mac_ctl_type        mac_ctl;
   logic signed [MA_W-1:0]       mac_a;
   logic [CW-1:0]                mac_b;
   logic signed [ACC_W-1:0]      acc;
   logic [AW-1:0]                rd_addr;
   logic [SW-1:0]                rd_data;
   logic                         out_free;
   logic signed [ACC_W-1:0]      rounded;
   logic [cfdl_pkg::REQ_W:0]     req_abs;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.audio_out     = rsp_audio_ff;
   assign rsp_ch.phase_code    = rsp_phase_ff;
   assign rsp_ch.delay_clamped = rsp_clamp_ff;

   // magnitude of the request, one bit wider so that the most negative value fits
   always_comb begin
      req_abs = {req_ch.delay_time[cfdl_pkg::REQ_W-1], req_ch.delay_time};
      if (req_ch.delay_time[cfdl_pkg::REQ_W-1]) begin
         req_abs = -req_abs;
      end
   end

   cfdl_store #(.SW(SW)) u_store (
      .clock   (clock),
      .wr_en   (state_ff == S_DECIDE),
      .wr_addr (wp_ff),
      .wr_data (smp_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfdl_mac #(.AW(MA_W), .ACC_W(ACC_W)) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (acc)
   );

   // store read address per step
   always_comb begin
      case (state_ff)
         S_RDA1:  rd_addr = base_ff + offa_ff + AW'(1);
         S_RDA0:  rd_addr = base_ff + offa_ff;
         S_RDB1:  rd_addr = base_ff + offb_ff + AW'(1);
         S_RDB0:  rd_addr = base_ff + offb_ff;
         default: rd_addr = base_ff;
      endcase
   end

   // operand selection for the shared multiply-accumulate
   always_comb begin
      mac_ctl = '{en: 1'b0, clear: 1'b0};
      mac_a   = '0;
      mac_b   = '0;
      case (state_ff)
         S_SCALE: begin
            mac_ctl = '{en: 1'b1, clear: 1'b1};
            mac_a   = $signed(MA_W'(mag_ff));
            mac_b   = CW'(ts_ff);
         end
         S_RDA0, S_RDB0: begin
            mac_ctl = '{en: 1'b1, clear: 1'b1};
            mac_a   = MA_W'($signed(rd_data));
            mac_b   = CW'(9'd256 - {1'b0, (state_ff == S_RDA0) ? fa_ff : fb_ff});
         end
         S_MA0, S_MB0: begin
            mac_ctl = '{en: 1'b1, clear: 1'b0};
            mac_a   = MA_W'($signed(rd_data));
            mac_b   = CW'((state_ff == S_MA0) ? fa_ff : fb_ff);
         end
         S_MIX1: begin
            mac_ctl = '{en: 1'b1, clear: 1'b1};
            mac_a   = MA_W'($signed(tapa_ff));
            mac_b   = cfdl_pkg::FADE_UNITY - c_ff;
         end
         S_MIX2: begin
            mac_ctl = '{en: 1'b1, clear: 1'b0};
            mac_a   = MA_W'($signed(tapb_ff));
            mac_b   = c_ff;
         end
         default: ;
      endcase
   end

   // per-word decision, taken from the scaled request in the accumulator
   always_comb begin
      logic [WANT_W-1:0]             want_raw;
      logic [DW-1:0]                 want, cur_s, gap;
      logic [FW-1:0]                 wfr, cfr_s, fa_raw, fb_raw;
      logic [OW-1:0]                 occ_push;
      logic [AW-1:0]                 wp_push;
      logic [cfdl_pkg::FADE_W:0]     fp_sum;
      logic [cfdl_pkg::FADE_W-1:0]   fp_adv;
      logic [cfdl_pkg::SCALE_W-1:0]  step_nz;
      logic [DW+1:0]                 occ_diff;
      logic [DW:0]                   drop;
      logic                          done;
      logic [DW-1:0]                 off_next;
      logic [DW-1:0]                 offa_w, offb_w;

      want_raw = acc[INT_HI:INT_LO];
      clamp_in = want_raw > WANT_W'(MAXD);
      want     = clamp_in ? MAXD : DW'(want_raw);
      wfr      = clamp_in ? '0 : acc[INT_LO-1:FRAC_LO];
      cur_s    = started_ff ? cur_ff : want;
      cfr_s    = started_ff ? cfr_ff : wfr;

      occ_push = (occ_ff == OW'(cfdl_pkg::STORE_DEPTH)) ? occ_ff : occ_ff + OW'(1);
      wp_push  = wp_ff + AW'(1);
      wp_in    = wp_push;
      base_in  = wp_push - occ_push[AW-1:0];

      step_nz  = (step_ff == '0) ? cfdl_pkg::SCALE_W'(1) : step_ff;
      fp_sum   = {1'b0, fp_ff} + (cfdl_pkg::FADE_W + 1)'(step_nz);
      fp_adv   = fp_sum[cfdl_pkg::FADE_W] ? cfdl_pkg::FADE_SAT : fp_sum[cfdl_pkg::FADE_W-1:0];
      done     = fp_adv[cfdl_pkg::FADE_W-1];
      c_in     = done ? cfdl_pkg::FADE_UNITY : CW'(fp_adv);

      fs_in    = fs_ff;
      tgt_in   = tgt_ff;
      tfr_in   = tfr_ff;
      off_in   = off_ff;
      cur_in   = cur_s;
      cfr_in   = cfr_s;
      fp_in    = fp_ff;
      occ_in   = occ_push;
      fill_in  = 1'b0;
      fade_in  = 1'b0;
      offa_w   = '0;
      offb_w   = '0;
      fa_raw   = cfr_s;
      fb_raw   = '0;
      phase_in = cfdl_pkg::PH_NORMAL;
      drop     = '0;
      occ_diff = '0;
      off_next = '0;
      gap      = '0;

      if ({4'b0, occ_ff} < {1'b0, cur_s} + (DW+1)'(1)) begin
         cur_in   = want;
         cfr_in   = wfr;
         fill_in  = 1'b1;
         phase_in = cfdl_pkg::PH_FILLING;
      end else if (want == cur_s && fs_ff == FS_NONE) begin
         cfr_in   = wfr;
         fa_raw   = wfr;
         occ_in   = occ_push - OW'(1);
         phase_in = cfdl_pkg::PH_NORMAL;
      end else begin
         if (fs_ff == FS_NONE) begin
            tgt_in = want;
            tfr_in = wfr;
            if (want < cur_s) begin
               off_in = cur_s - want;
               fs_in  = FS_SHRINK;
            end else begin
               fs_in  = FS_GROW;
            end
         end
         case (fs_in)
            FS_SHRINK: begin
               fade_in  = 1'b1;
               offb_w   = off_in;
               fb_raw   = tfr_in;
               phase_in = cfdl_pkg::PH_SHRINK;
               drop     = (DW+1)'(1) + (done ? {1'b0, off_in} : '0);
               occ_diff = (DW+2)'(occ_push) - (DW+2)'(drop);
               occ_in   = occ_diff[DW+1] ? '0 : OW'(occ_diff);
               fp_in    = fp_adv;
               if (done) begin
                  fs_in  = FS_NONE;
                  fp_in  = '0;
                  cur_in = tgt_in;
                  cfr_in = tfr_in;
                  off_in = '0;
               end
            end
            FS_BACK: begin
               fade_in  = 1'b1;
               offa_w   = off_in;
               fb_raw   = tfr_in;
               phase_in = cfdl_pkg::PH_GROW_FADE;
               occ_in   = occ_push - OW'(1);
               fp_in    = fp_adv;
               if (done) begin
                  fs_in  = FS_NONE;
                  fp_in  = '0;
                  off_in = '0;
                  cur_in = tgt_in;
                  cfr_in = tfr_in;
               end
            end
            default: begin
               // growing: read the old tap while the store lengthens
               offa_w   = off_in;
               phase_in = cfdl_pkg::PH_GROWING;
               off_next = off_in + DW'(1);
               gap      = tgt_in - cur_s;
               if (off_next == gap) begin
                  fs_in = FS_BACK;
               end
               off_in   = off_next;
            end
         endcase
      end

      offa_in = offa_w[AW-1:0];
      offb_in = offb_w[AW-1:0];
      fa_in   = im_ff ? fa_raw : '0;
      fb_in   = im_ff ? fb_raw : '0;
   end

   // round to nearest, ties upward
   always_comb begin
      if (fade_ff) begin
         rounded = (acc + (ACC_W'(1) <<< 23)) >>> 24;
      end else begin
         rounded = (acc + ACC_W'(128)) >>> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fs_ff        <= FS_NONE;
         ts_ff        <= cfdl_pkg::RST_TIME_SCALE;
         im_ff        <= cfdl_pkg::RST_INTERP_MODE;
         step_ff      <= cfdl_pkg::RST_XFADE_STEP;
         wp_ff        <= '0;
         occ_ff       <= '0;
         cur_ff       <= '0;
         cfr_ff       <= '0;
         tgt_ff       <= '0;
         tfr_ff       <= '0;
         off_ff       <= '0;
         fp_ff        <= '0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            case (csr_ch.index)
               cfdl_pkg::REG_TIME_SCALE:  ts_ff   <= csr_ch.data;
               cfdl_pkg::REG_INTERP_MODE: im_ff   <= csr_ch.data[0];
               cfdl_pkg::REG_XFADE_STEP:  step_ff <= csr_ch.data;
               default: ;
            endcase
         end
         if (state_ff == S_ROUND && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  smp_ff   <= req_ch.audio_in;
                  mag_ff   <= req_abs[cfdl_pkg::REQ_W-1:0];
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: state_ff <= S_DECIDE;
            S_DECIDE: begin
               fs_ff      <= fs_in;
               wp_ff      <= wp_in;
               occ_ff     <= occ_in;
               cur_ff     <= cur_in;
               cfr_ff     <= cfr_in;
               tgt_ff     <= tgt_in;
               tfr_ff     <= tfr_in;
               off_ff     <= off_in;
               fp_ff      <= fp_in;
               started_ff <= 1'b1;
               base_ff    <= base_in;
               offa_ff    <= offa_in;
               offb_ff    <= offb_in;
               fa_ff      <= fa_in;
               fb_ff      <= fb_in;
               c_ff       <= c_in;
               fade_ff    <= fade_in;
               fill_ff    <= fill_in;
               clamp_ff   <= clamp_in;
               phase_ff   <= phase_in;
               state_ff   <= fill_in ? S_ROUND : S_RDA1;
            end
            S_RDA1: state_ff <= S_RDA0;
            S_RDA0: state_ff <= S_MA0;
            S_MA0:  state_ff <= fade_ff ? S_RDB1 : S_ROUND;
            S_RDB1: begin
               tapa_ff  <= acc[TAP_W-1:0];
               state_ff <= S_RDB0;
            end
            S_RDB0: state_ff <= S_MB0;
            S_MB0:  state_ff <= S_MIX1;
            S_MIX1: begin
               tapb_ff  <= acc[TAP_W-1:0];
               state_ff <= S_MIX2;
            end
            S_MIX2: state_ff <= S_ROUND;
            S_ROUND: begin
               if (out_free) begin
                  rsp_audio_ff <= fill_ff ? '0 : rounded[SW-1:0];
                  rsp_phase_ff <= phase_ff;
                  rsp_clamp_ff <= clamp_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/cfdl_checker.sv -----
module cfdl_checker #(
   parameter int SW = cfdl_pkg::DEF_SAMPLE_WIDTH
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [SW-1:0]                audio_out,
   input logic [cfdl_pkg::PHASE_W-1:0] phase_code
);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(audio_out) && $stable(phase_code))
      else $error("stalled result word changed");

   // one word in flight: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again straight after accept");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (phase_code <= cfdl_pkg::PH_GROW_FADE))
      else $error("phase code out of range");

   a_fill_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (phase_code == cfdl_pkg::PH_FILLING) |-> (audio_out == '0))
      else $error("non-zero output while filling");

endmodule

bind crossfading_fractional_delay_line cfdl_checker #(.SW(SAMPLE_WIDTH)) u_cfdl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .audio_out  (rsp_ch.audio_out),
   .phase_code (rsp_ch.phase_code)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import cfdl_pkg::*;

   localparam int WATCH_LIMIT = 4000;

   typedef enum logic [1:0] {FADE_IDLE, FADE_SHRINK, FADE_BACK, FADE_GROW} fade_e;

   typedef struct {
      logic [23:0] audio;
      phase_type   phase;
      logic        clamp;
   } tap_word_t;

   class delay_scoreboard;
      logic [23:0]   store_mem [STORE_DEPTH];
      int unsigned   wr_ptr, fill, cur_d, cur_f, tgt_d, tgt_f, tap_off, fade_pos;
      fade_e         fade_st;
      bit            started;
      int unsigned   scale, interp, step;
      tap_word_t     pending_q [$];

      function new();
         wr_ptr = 0; fill = 0; cur_d = 0; cur_f = 0; tgt_d = 0; tgt_f = 0;
         tap_off = 0; fade_pos = 0; fade_st = FADE_IDLE; started = 0;
         scale = RST_TIME_SCALE; interp = RST_INTERP_MODE; step = RST_XFADE_STEP;
      endfunction

      function void set_reg(csr_idx_type idx, logic [CSR_DW-1:0] val);
         case (idx)
            REG_TIME_SCALE:  scale = val;
            REG_INTERP_MODE: interp = val[0];
            REG_XFADE_STEP:  step = val;
            default: ;
         endcase
      endfunction

      function void push(logic [23:0] s);
         store_mem[wr_ptr] = s;
         wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
         if (fill < STORE_DEPTH) fill++;
      endfunction

      function void drop(int unsigned n);
         fill = (n > fill) ? 0 : fill - n;
      endfunction

      function longint rd(int unsigned i);
         logic signed [23:0] v;
         v = store_mem[(wr_ptr - fill + i) % STORE_DEPTH];
         return longint'(v);
      endfunction

      function longint tap(int unsigned i, int unsigned f);
         if (interp == 0) f = 0;
         return rd(i + 1) * longint'(256 - f) + rd(i) * longint'(f);
      endfunction

      function longint mix(longint from_v, longint to_v);
         longint c;
         c = (fade_pos > 65536) ? 65536 : fade_pos;
         return (from_v * (65536 - c) + to_v * c + (longint'(1) << 23)) >>> 24;
      endfunction

      function void advance();
         fade_pos += (step == 0) ? 1 : step;
         if (fade_pos > 131071) fade_pos = 131071;
      endfunction

      // predicts the word that this accepted request produces
      function void note(logic [23:0] a, logic [23:0] dt);
         longint      rq, mag, scaled, want_i, res;
         int unsigned want, wf;
         logic        clamp;
         phase_type   ph;
         tap_word_t   w;
         rq = longint'($signed(dt));
         mag = (rq < 0) ? -rq : rq;
         scaled = (mag * scale) >> SCALE_SHIFT;
         want_i = scaled >> 8;
         wf = 32'(scaled & 255);
         clamp = 0;
         res = 0;
         if (want_i > DEF_MAX_DELAY) begin
            want_i = DEF_MAX_DELAY; wf = 0; clamp = 1;
         end
         want = 32'(want_i);
         if (!started) begin
            started = 1; cur_d = want; cur_f = wf;
         end
         if (fill < cur_d + 1) begin
            cur_d = want; cur_f = wf;
            push(a);
            ph = PH_FILLING;
         end else if (want == cur_d && fade_st == FADE_IDLE) begin
            cur_f = wf;
            push(a);
            res = (tap(0, cur_f) + 128) >>> 8;
            drop(1);
            ph = PH_NORMAL;
         end else begin
            if (fade_st == FADE_IDLE) begin
               tgt_d = want; tgt_f = wf;
               if (want < cur_d) begin
                  tap_off = cur_d - want; fade_st = FADE_SHRINK;
               end else begin
                  fade_st = FADE_GROW;
               end
            end
            push(a);
            if (fade_st == FADE_SHRINK) begin
               advance();
               res = mix(tap(0, cur_f), tap(tap_off, tgt_f));
               drop(1);
               if (fade_pos >= 65536) begin
                  fade_st = FADE_IDLE; fade_pos = 0;
                  cur_d = tgt_d; cur_f = tgt_f;
                  drop(tap_off);
                  tap_off = 0;
               end
               ph = PH_SHRINK;
            end else if (fade_st == FADE_BACK) begin
               advance();
               res = mix(tap(tap_off, cur_f), tap(0, tgt_f));
               drop(1);
               if (fade_pos >= 65536) begin
                  fade_st = FADE_IDLE; fade_pos = 0; tap_off = 0;
                  cur_d = tgt_d; cur_f = tgt_f;
               end
               ph = PH_GROW_FADE;
            end else begin
               res = (tap(tap_off, cur_f) + 128) >>> 8;
               tap_off = (tap_off + 1) & 16'hFFFF;
               if (tap_off == ((tgt_d - cur_d) & 16'hFFFF)) fade_st = FADE_BACK;
               ph = PH_GROWING;
            end
         end
         w.audio = res[23:0];
         w.phase = ph;
         w.clamp = clamp;
         pending_q.push_back(w);
      endfunction

      // empty string when the word matches the oldest prediction
      function string check(logic [23:0] a, phase_type ph, logic cl);
         tap_word_t w;
         if (pending_q.size() == 0) return "word with no prediction waiting";
         w = pending_q.pop_front();
         if (a !== w.audio)
            return $sformatf("audio_out %h, predicted %h", a, w.audio);
         if (ph !== w.phase)
            return $sformatf("phase_code %0d, predicted %0d", ph, w.phase);
         if (cl !== w.clamp)
            return $sformatf("delay_clamped %b, predicted %b", cl, w.clamp);
         return "";
      endfunction
   endclass

   logic clock;
   logic reset;

   cfdl_req_if req_if ();
   cfdl_rsp_if rsp_if ();
   cfdl_csr_if csr_if ();

   crossfading_fractional_delay_line u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   delay_scoreboard tap_sb = new();
   int          mismatches = 0;
   int          rsp_count = 0;
   int          idle_cycles = 0;
   int          rsp_hold = 0;
   int          rsp_quiet = 0;
   bit          pressed = 0;
   int          req_quiet = 0;
   bit          steady = 0;
   logic [23:0] hold_word = '0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic report(string msg);
      $display("tb_top: mismatch at word %0d: %s", rsp_count, msg);
      mismatches++;
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 5);
   endfunction

   // request word for a delay of about samp samples at the present time_scale
   function automatic logic [23:0] delay_word(int samp);
      longint m;
      if (tap_sb.scale == 0) return 24'($urandom);
      m = ((longint'(samp) * 256 + $urandom_range(255)) * 4096) / tap_sb.scale;
      if (m > 8388607) m = 8388607;
      if ($urandom_range(1)) m = -m;
      return m[23:0];
   endfunction

   function automatic logic [23:0] next_delay();
      int r;
      if (tap_sb.fade_st != FADE_IDLE && $urandom_range(1)) return 24'($urandom);
      if (steady) return 24'(tap_sb.cur_d * 256 + $urandom_range(255));
      if ($urandom_range(11) == 0) begin
         r = $urandom_range(99);
         if (r < 85) hold_word = delay_word($urandom_range(48));
         else if (r < 97) hold_word = delay_word($urandom_range(300, 49));
         else hold_word = delay_word($urandom_range(1500, 301));
      end
      return hold_word;
   endfunction

   task automatic send(logic [23:0] a, logic [23:0] dt);
      int g;
      if (req_quiet > 0) begin
         g = 0; req_quiet--;
      end else begin
         g = gap_len();
         if ($urandom_range(150) == 0) req_quiet = 60;
      end
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.audio_in   <= a;
      req_if.delay_time <= dt;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tap_sb.note(a, dt);
   endtask

   task automatic run_items(int n);
      repeat (n) send(24'($urandom), next_delay());
   endtask

   // bring any fade to its end so that a slow fade step cannot start one
   task automatic settle();
      while (tap_sb.fade_st != FADE_IDLE) send(24'($urandom), next_delay());
   endtask

   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (tap_sb.pending_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(csr_idx_type idx, logic [CSR_DW-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      tap_sb.set_reg(idx, val);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            string msg;
            msg = tap_sb.check(rsp_if.audio_out, rsp_if.phase_code, rsp_if.delay_clamped);
            if (msg != "") report(msg);
            rsp_count++;
         end
         // one long hold-off so that the block backs up onto its input
         if (!pressed && rsp_count == 900) begin
            pressed = 1;
            rsp_hold = 400;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_if.ready <= 1'b0;
         end else if (rsp_quiet > 0) begin
            rsp_quiet--;
            rsp_if.ready <= 1'b1;
         end else if ($urandom_range(300) == 0) begin
            rsp_quiet = 200;
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_hold = gap_len();
            rsp_if.ready <= (rsp_hold == 0);
            if (rsp_hold > 0) rsp_hold--;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.audio_in   <= '0;
      req_if.delay_time <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= REG_TIME_SCALE;
      csr_if.data       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // delay lowered while the store is still filling
      send(24'h7FFFFF, 24'd1280);
      send(24'h800000, 24'd0);
      send(24'h000000, 24'd0);
      send(24'hFFFFFF, 24'd0);
      send(24'h000001, 24'd0);
      // grow to 3.5 samples, then clamped requests that the fade ignores
      send(24'h123456, 24'd896);
      for (int i = 0; i < 18; i++)
         send(24'($urandom), (i % 2) ? 24'h800000 : 24'h7FFFFF);
      hold_word = 24'd896;
      run_items(400);
      quiesce();

      csr_write(REG_TIME_SCALE, 16'hFFFF);
      csr_write(REG_INTERP_MODE, 16'd0);
      csr_write(REG_XFADE_STEP, 16'hFFFF);
      hold_word = delay_word(10);
      run_items(300);
      settle();
      quiesce();

      csr_write(REG_TIME_SCALE, 16'd4096);
      csr_write(REG_INTERP_MODE, 16'd1);
      csr_write(REG_XFADE_STEP, 16'd0);
      steady = 1;
      run_items(60);
      quiesce();
      csr_write(REG_XFADE_STEP, 16'd1);
      run_items(60);
      steady = 0;
      quiesce();

      csr_write(REG_TIME_SCALE, 16'd0);
      csr_write(REG_XFADE_STEP, 16'd40000);
      run_items(150);
      quiesce();

      csr_write(REG_TIME_SCALE, 16'($urandom_range(8192, 1024)));
      csr_write(REG_INTERP_MODE, 16'($urandom_range(1)));
      csr_write(REG_XFADE_STEP, 16'($urandom_range(30000, 2000)));
      run_items(550);
      quiesce();
      repeat (40) @(posedge clock);

      if (mismatches == 0 && tap_sb.pending_q.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
